[hdl/mkds_pkg.sv]
package mkds_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 3;
  localparam int LABEL_COUNT = 12;
  localparam int SCAN_KEYS = (ROWS * COLS < LABEL_COUNT) ? ROWS * COLS : LABEL_COUNT;

  localparam int MATRIX_W = 12;
  localparam int CHAR_W = 8;
  localparam int PHASE_W = 2;
  localparam int DEBOUNCE_W = 10;
  localparam int TICK_W = 8;
  localparam int ELAPSED_W = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PERIOD = 1'b1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd40;
  localparam logic [TICK_W-1:0] TICK_RESET = 8'd10;

  localparam logic [CHAR_W-1:0] NO_KEY = 8'h00;

  typedef logic [3:0] key_index_t;

  function automatic logic [CHAR_W-1:0] key_label(input key_index_t idx);
    logic [CHAR_W-1:0] label;
    unique case (idx)
      4'd0:    label = "1";
      4'd1:    label = "2";
      4'd2:    label = "3";
      4'd3:    label = "4";
      4'd4:    label = "5";
      4'd5:    label = "6";
      4'd6:    label = "7";
      4'd7:    label = "8";
      4'd8:    label = "9";
      4'd9:    label = "*";
      4'd10:   label = "0";
      4'd11:   label = "#";
      default: label = NO_KEY;
    endcase
    return label;
  endfunction

endpackage

[hdl/mkds_if.sv]
interface mkds_in_if;
  logic valid;
  logic ready;
  logic [mkds_pkg::MATRIX_W-1:0] key_matrix;

  modport source (output valid, output key_matrix, input ready);
  modport sink (input valid, input key_matrix, output ready);
endinterface

interface mkds_out_if;
  logic valid;
  logic ready;
  logic [mkds_pkg::CHAR_W-1:0] released_char;
  logic [mkds_pkg::PHASE_W-1:0] scan_phase;

  modport source (output valid, output released_char, output scan_phase, input ready);
  modport sink (input valid, input released_char, input scan_phase, output ready);
endinterface

[hdl/mkds_scan.sv]
module mkds_scan (
  input  logic [mkds_pkg::MATRIX_W-1:0] matrix,
  output logic [mkds_pkg::CHAR_W-1:0]   label
);

  always_comb begin
    label = mkds_pkg::NO_KEY;
    // Walk from the last key down so that the lowest-numbered pressed key wins.
    for (int i = mkds_pkg::SCAN_KEYS - 1; i >= 0; i--) begin
      if (matrix[i]) begin
        label = mkds_pkg::key_label(mkds_pkg::key_index_t'(i));
      end
    end
  end

endmodule

[hdl/matrix_keypad_debounce_scanner_unit.sv]
// Keypad scanner with debounce. Each request carries one tick's sample of the
// 4x3 key matrix and yields exactly one result holding the label of a key
// released on that tick (zero if none) and the scanner phase after the tick.
// A request is registered on acceptance and resolved by a priority encoder and
// a small state update once the output register is free or being read, so one
// request per cycle is sustained while results are taken; the output register
// lets a new request enter while a result waits to be taken. Configuration
// writes to the debounce time and tick period are registered when cfg_write_en is high.
module matrix_keypad_debounce_scanner_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [mkds_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mkds_pkg::CFG_DATA_W-1:0]       cfg_data,
  mkds_in_if.sink                               keys,
  mkds_out_if.source                            result
);

  typedef enum logic [mkds_pkg::PHASE_W-1:0] {
    SCANNING = 2'd0,
    DEBOUNCE = 2'd1,
    HOLD     = 2'd2
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic [mkds_pkg::CHAR_W-1:0] held_char;
  logic [mkds_pkg::CHAR_W-1:0] held_char_next;
  logic [mkds_pkg::ELAPSED_W-1:0] elapsed;
  logic [mkds_pkg::ELAPSED_W-1:0] elapsed_next;
  logic [mkds_pkg::ELAPSED_W:0] elapsed_sum;
  logic [mkds_pkg::CHAR_W-1:0] released_next;

  logic [mkds_pkg::DEBOUNCE_W-1:0] debounce_time;
  logic [mkds_pkg::TICK_W-1:0] tick_period;

  logic stage_valid;
  logic [mkds_pkg::MATRIX_W-1:0] stage_matrix;
  logic out_valid;
  logic [mkds_pkg::CHAR_W-1:0] out_released;
  logic [mkds_pkg::PHASE_W-1:0] out_phase;

  logic advance;
  logic take_in;
  logic [mkds_pkg::CHAR_W-1:0] key;

  mkds_scan u_scan (
    .matrix (stage_matrix),
    .label  (key)
  );

  assign advance = stage_valid && (!out_valid || result.ready);
  assign take_in = keys.valid && keys.ready;
  assign keys.ready = !stage_valid || advance;

  assign result.valid = out_valid;
  assign result.released_char = out_released;
  assign result.scan_phase = out_phase;

  assign elapsed_sum = {1'b0, elapsed} + {{(mkds_pkg::ELAPSED_W + 1 - mkds_pkg::TICK_W){1'b0}},
                                          tick_period};

  always_comb begin
    phase_next = phase;
    held_char_next = held_char;
    elapsed_next = elapsed;
    released_next = mkds_pkg::NO_KEY;
    unique case (phase)
      SCANNING: begin
        if (key != mkds_pkg::NO_KEY) begin
          held_char_next = key;
          elapsed_next = '0;
          phase_next = DEBOUNCE;
        end
      end
      DEBOUNCE: begin
        if (elapsed >= {1'b0, debounce_time}) begin
          phase_next = (key == held_char) ? HOLD : SCANNING;
        end
        elapsed_next = elapsed_sum[mkds_pkg::ELAPSED_W] ? '1
                                                         : elapsed_sum[mkds_pkg::ELAPSED_W-1:0];
      end
      HOLD: begin
        if (key != held_char) begin
          if (key == mkds_pkg::NO_KEY) begin
            released_next = held_char;
          end
          phase_next = SCANNING;
        end
      end
      default: begin
        phase_next = SCANNING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SCANNING;
      held_char <= mkds_pkg::NO_KEY;
      elapsed <= '0;
      debounce_time <= mkds_pkg::DEBOUNCE_RESET;
      tick_period <= mkds_pkg::TICK_RESET;
      stage_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          mkds_pkg::CFG_DEBOUNCE_TIME: debounce_time <= cfg_data[mkds_pkg::DEBOUNCE_W-1:0];
          mkds_pkg::CFG_TICK_PERIOD:   tick_period <= cfg_data[mkds_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if (advance) begin
        phase <= phase_next;
        held_char <= held_char_next;
        elapsed <= elapsed_next;
      end
      if (take_in) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      stage_matrix <= keys.key_matrix;
    end
    if (advance) begin
      out_released <= released_next;
      out_phase <= phase_next;
    end
  end

endmodule
